FILE: hw/rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared constants for the fixed-size block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    // Largest pool the allocator is built for.
    localparam int MAX_BLOCKS_DEFAULT = 256;

    // Field widths of the stream words and the registers.
    localparam int INDEX_W  = 8;
    localparam int OFFSET_W = 20;
    localparam int COUNT_W  = 9;
    localparam int BYTES_W  = 13;

    // Block size limits; a block must be able to hold a link.
    localparam logic [BYTES_W-1:0] MIN_BLOCK_BYTES = 13'd8;
    localparam logic [BYTES_W-1:0] MAX_BLOCK_BYTES = 13'd4096;

    // Register reset values.
    localparam logic [COUNT_W-1:0] BLOCK_COUNT_RESET = 9'd256;
    localparam logic [BYTES_W-1:0] BLOCK_BYTES_RESET = 13'd8;

    // Register indexes, taken from bit 2 of the byte address.
    localparam logic REG_BLOCK_COUNT = 1'b0;
    localparam logic REG_BLOCK_BYTES = 1'b1;

    // Request kinds.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

endpackage

FILE: hw/rtl/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module fbpa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool with a last-in-first-out free list.
//
// The pool hands out blocks of one size from a free list that threads
// through a link memory. Each input word is either an allocate (pop the
// head block, return its index and byte offset) or a free (push the given
// block onto the head); a null free changes nothing. Every input word gives
// exactly one output word. A request has an accept cycle and an execute
// cycle: the link of the head block is read from the synchronous link RAM
// in the accept cycle and the list is updated in the next; no new word is
// taken during execute or while a result waits unread. A write to either
// register rebuilds the ascending free list at once: per-block valid bits
// are cleared, and a block whose link was never written reads as the next
// block of the initial chain. Frees are not checked for range or double
// free, only an index beyond the pool storage is dropped.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
    parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,

    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] block_index
    input  logic [1:0]  s_axis_tuser,   // [0] mode, [1] is_null

    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] alloc_index, [27:8] byte_offset,
                                        // [28] pool_empty, [31:29] zero
    output logic [0:0]  m_axis_tuser,   // [0] granted

    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
    localparam int CNT_W  = (LINK_W > fbpa_pkg::COUNT_W) ? LINK_W : fbpa_pkg::COUNT_W;
    localparam int WIDE_W = LINK_W + fbpa_pkg::INDEX_W;
    localparam int PROD_W = IDX_W + fbpa_pkg::BYTES_W;

    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t                         state_reg, state_next;
    logic [fbpa_pkg::COUNT_W-1:0]   block_count_reg;
    logic [fbpa_pkg::BYTES_W-1:0]   block_bytes_reg;
    logic [LINK_W-1:0]              head_reg, head_next;
    logic [MAX_BLOCKS-1:0]          valid_reg;

    logic                           req_mode_reg;
    logic [fbpa_pkg::INDEX_W-1:0]   req_idx_reg;
    logic                           req_null_reg;

    logic                           out_valid_reg;
    logic                           granted_reg;
    logic [fbpa_pkg::INDEX_W-1:0]   alloc_index_reg;
    logic [fbpa_pkg::OFFSET_W-1:0]  byte_offset_reg;
    logic                           pool_empty_reg;

    logic                           in_fire;
    logic                           cfg_wr;
    logic [CNT_W-1:0]               count_wide;
    logic [LINK_W-1:0]              eff_count;
    logic [fbpa_pkg::BYTES_W-1:0]   eff_bytes;

    logic                           head_is_null;
    logic [IDX_W-1:0]               head_addr;
    logic [LINK_W-1:0]              ram_q;
    logic [LINK_W-1:0]              head_plus;
    logic [LINK_W-1:0]              init_link;
    logic [LINK_W-1:0]              pop_link;
    logic [WIDE_W-1:0]              free_wide;
    logic                           free_ok;
    logic                           pop_ok;
    logic [PROD_W-1:0]              product;

    logic                           ram_wr_en;

    // Handshakes.
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_axis_tready);
    assign cfg_wr        = psel && penable && pwrite && pready;
    assign pready        = 1'b1;

    // Register read back.
    always_comb
    begin
        unique case (paddr[2])
            fbpa_pkg::REG_BLOCK_COUNT: prdata = 32'(block_count_reg);
            fbpa_pkg::REG_BLOCK_BYTES: prdata = 32'(block_bytes_reg);
            default:                   prdata = '0;
        endcase
    end

    // Effective pool size and block size after clamping.
    assign count_wide = CNT_W'(block_count_reg);
    always_comb
    begin
        priority if (count_wide == '0)
            eff_count = LINK_W'(1);
        else if (count_wide > CNT_W'(MAX_BLOCKS))
            eff_count = NULL_LINK;
        else
            eff_count = LINK_W'(count_wide);
    end

    always_comb
    begin
        priority if (block_bytes_reg < fbpa_pkg::MIN_BLOCK_BYTES)
            eff_bytes = fbpa_pkg::MIN_BLOCK_BYTES;
        else if (block_bytes_reg > fbpa_pkg::MAX_BLOCK_BYTES)
            eff_bytes = fbpa_pkg::MAX_BLOCK_BYTES;
        else
            eff_bytes = block_bytes_reg;
    end

    // Link lookup for the head block; the RAM is read every cycle at the head.
    assign head_is_null = (head_reg >= NULL_LINK);
    assign head_addr    = IDX_W'(head_reg);
    assign head_plus    = head_reg + LINK_W'(1);
    assign init_link    = (head_plus < eff_count) ? head_plus : NULL_LINK;
    assign pop_link     = valid_reg[head_addr] ? ram_q : init_link;

    // Request decode in the execute cycle.
    assign free_wide = WIDE_W'(req_idx_reg);
    assign free_ok   = (req_mode_reg == fbpa_pkg::MODE_FREE) && !req_null_reg
                       && (free_wide < WIDE_W'(MAX_BLOCKS));
    assign pop_ok    = (req_mode_reg == fbpa_pkg::MODE_ALLOC) && !head_is_null;
    assign product   = head_addr * eff_bytes;

    assign ram_wr_en = (state_reg == ST_EXEC) && free_ok;

    fbpa_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_BLOCKS)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (IDX_W'(free_wide)),
        .wr_data (head_reg),
        .rd_addr (head_addr),
        .rd_data (ram_q)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_EXEC;
            ST_EXEC: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Head of the free list after this request.
    always_comb
    begin
        head_next = head_reg;
        priority if (pop_ok)
            head_next = pop_link;
        else if (free_ok)
            head_next = LINK_W'(free_wide);
        else
            head_next = head_reg;
    end

    // Control state, configuration and list head.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            block_count_reg <= fbpa_pkg::BLOCK_COUNT_RESET;
            block_bytes_reg <= fbpa_pkg::BLOCK_BYTES_RESET;
            head_reg        <= '0;
            valid_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
            begin
                unique case (paddr[2])
                    fbpa_pkg::REG_BLOCK_COUNT:
                        block_count_reg <= pwdata[fbpa_pkg::COUNT_W-1:0];
                    fbpa_pkg::REG_BLOCK_BYTES:
                        block_bytes_reg <= pwdata[fbpa_pkg::BYTES_W-1:0];
                    default: ;
                endcase
                head_reg  <= '0;
                valid_reg <= '0;
            end
            else if (state_reg == ST_EXEC)
            begin
                head_reg <= head_next;
                if (free_ok)
                begin
                    valid_reg[IDX_W'(free_wide)] <= 1'b1;
                end
            end

            if (state_reg == ST_EXEC)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Request capture and result word.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_mode_reg <= s_axis_tuser[0];
            req_null_reg <= s_axis_tuser[1];
            req_idx_reg  <= s_axis_tdata;
        end
        if (state_reg == ST_EXEC)
        begin
            granted_reg     <= pop_ok;
            alloc_index_reg <= pop_ok ? fbpa_pkg::INDEX_W'(head_addr) : '0;
            byte_offset_reg <= pop_ok ? fbpa_pkg::OFFSET_W'(product) : '0;
            pool_empty_reg  <= (head_next >= NULL_LINK);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = granted_reg;
    assign m_axis_tdata  = {3'b000, pool_empty_reg, byte_offset_reg, alloc_index_reg};

    // An accepted word is always followed by its execute cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_EXEC))
        else $error("accepted request did not enter execute");

    // Every execute cycle leaves a result word behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |=> out_valid_reg)
        else $error("execute cycle produced no result");

    // No new request is taken while one is being executed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> !s_axis_tready)
        else $error("request accepted during execute");

    // A result that grants nothing carries a zero index and offset.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !granted_reg) |-> (alloc_index_reg == '0 && byte_offset_reg == '0))
        else $error("ungranted result carries a block");

    // A register write restarts the free list from block zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr |=> (head_reg == '0 && valid_reg == '0))
        else $error("configuration write did not rebuild the free list");

endmodule
